// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the ASCII formatter.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/i2a_pkg.sv -----
// Package of the integer to ASCII formatter: selector codes, state type,
// buffer sizes, character constants and the digit to character function.
`timescale 1ns / 1ps
`default_nettype none
package i2a_pkg;

    typedef enum logic [2:0] {
        FN_SDEC    = 3'd0,
        FN_UDEC    = 3'd1,
        FN_OCT     = 3'd2,
        FN_OCT_ALT = 3'd3,
        FN_HEX_L   = 3'd4,
        FN_HEX_U   = 3'd5,
        FN_HEXP_L  = 3'd6,
        FN_HEXP_U  = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DABBLE,
        S_SKIP,
        S_PREFIX,
        S_DIGITS
    } state_t;

    localparam int VALUE_W = 64;
    localparam int DIG_W   = 88;
    localparam int CNT_W   = 5;
    localparam int STEP_W  = 6;
    localparam int CHAR_W  = 7;

    localparam logic [CNT_W-1:0] DEC_DIGITS  = 5'd20;
    localparam logic [CNT_W-1:0] OCT_DIGITS  = 5'd22;
    localparam logic [CNT_W-1:0] HEX_NIBBLES = 5'd16;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
    localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10)
        begin
            digit_char = CH_ZERO + {3'b000, d};
        end
        else
        begin
            digit_char = base + {3'b000, d} - 7'd10;
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/integer_to_ascii_formatter_core.sv -----
// Top level of the integer to ASCII formatter: one module, serial datapath.
// Depends on i2a_pkg and assert_macros.svh.
// Sequence: an accepted item passes through S_DABBLE (decimal only), then S_SKIP, which drops
// suppressed leading zeros, then S_PREFIX (if a prefix is set) and S_DIGITS, which register the characters.
// Throughput: one character per cycle while the output is taken; s_tready is high only in idle,
// so an item holds the input until its last digit has been registered on the output.
// Reset: rst_n is asynchronous and active low; it returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module integer_to_ascii_formatter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // value[63:0]
    input  wire logic [2:0]  s_tuser,   // func[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // char_code[6:0], zero pad[7]
    output logic             m_tlast    // last
);

    i2a_pkg::state_t                    state_reg, state_next;
    i2a_pkg::func_t                     func_reg, func_next;
    logic [i2a_pkg::VALUE_W-1:0]        bin_reg, bin_next;
    logic [i2a_pkg::DIG_W-1:0]          dig_reg, dig_next;
    logic [i2a_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [i2a_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [2*i2a_pkg::CHAR_W-1:0]       pre_reg, pre_next;
    logic [1:0]                         pre_len_reg, pre_len_next;
    logic                               m_valid_reg, m_valid_next;
    logic [i2a_pkg::CHAR_W-1:0]         char_reg, char_next;
    logic                               last_reg, last_next;

    i2a_pkg::func_t                     in_func;
    logic                               out_free;
    logic                               is_oct;
    logic                               is_upper;
    logic [3:0]                         top_digit;
    logic                               skip_zero;
    logic [i2a_pkg::DIG_W-1:0]          dig_shift;
    logic [79:0]                        bcd_corr;
    logic [i2a_pkg::VALUE_W-1:0]        mag;

    assign in_func   = i2a_pkg::func_t'(s_tuser);
    assign out_free  = !m_valid_reg || m_tready;
    assign is_oct    = (func_reg == i2a_pkg::FN_OCT) || (func_reg == i2a_pkg::FN_OCT_ALT);
    assign is_upper  = (func_reg == i2a_pkg::FN_HEX_U) || (func_reg == i2a_pkg::FN_HEXP_U);
    assign top_digit = is_oct ? {1'b0, dig_reg[i2a_pkg::DIG_W-1 -: 3]}
                              : dig_reg[i2a_pkg::DIG_W-1 -: 4];
    assign dig_shift = is_oct ? (dig_reg << 3) : (dig_reg << 4);
    assign skip_zero = (top_digit == 4'd0) && (cnt_reg > 5'd1);
    assign mag       = ((in_func == i2a_pkg::FN_SDEC) && s_tdata[63]) ? (64'd0 - s_tdata)
                                                                     : s_tdata;

    always_comb
    begin
        for (int i = 0; i < 20; i++)
        begin
            bcd_corr[4*i +: 4] = (dig_reg[8+4*i +: 4] >= 4'd5) ? (dig_reg[8+4*i +: 4] + 4'd3)
                                                               : dig_reg[8+4*i +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            i2a_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if ((in_func == i2a_pkg::FN_SDEC) || (in_func == i2a_pkg::FN_UDEC))
                    begin
                        state_next = i2a_pkg::S_DABBLE;
                    end
                    else
                    begin
                        state_next = i2a_pkg::S_SKIP;
                    end
                end
            end
            i2a_pkg::S_DABBLE:
            begin
                if (step_reg == '0)
                begin
                    state_next = i2a_pkg::S_SKIP;
                end
            end
            i2a_pkg::S_SKIP:
            begin
                if (!skip_zero)
                begin
                    state_next = (pre_len_reg != 2'd0) ? i2a_pkg::S_PREFIX : i2a_pkg::S_DIGITS;
                end
            end
            i2a_pkg::S_PREFIX:
            begin
                if (out_free && (pre_len_reg == 2'd1))
                begin
                    state_next = i2a_pkg::S_DIGITS;
                end
            end
            i2a_pkg::S_DIGITS:
            begin
                if (out_free && (cnt_reg == 5'd1))
                begin
                    state_next = i2a_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = i2a_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        func_next    = func_reg;
        bin_next     = bin_reg;
        dig_next     = dig_reg;
        cnt_next     = cnt_reg;
        step_next    = step_reg;
        pre_next     = pre_reg;
        pre_len_next = pre_len_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = (state_reg == i2a_pkg::S_IDLE);
        unique case (state_reg)
            i2a_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next    = in_func;
                    bin_next     = mag;
                    step_next    = '1;
                    pre_next     = '0;
                    pre_len_next = 2'd0;
                    unique case (in_func)
                        i2a_pkg::FN_SDEC, i2a_pkg::FN_UDEC:
                        begin
                            dig_next = '0;
                            cnt_next = i2a_pkg::DEC_DIGITS;
                            if ((in_func == i2a_pkg::FN_SDEC) && s_tdata[63])
                            begin
                                pre_next     = {i2a_pkg::CH_MINUS, 7'd0};
                                pre_len_next = 2'd1;
                            end
                        end
                        i2a_pkg::FN_OCT, i2a_pkg::FN_OCT_ALT:
                        begin
                            dig_next = {2'b00, s_tdata, 22'd0};
                            cnt_next = i2a_pkg::OCT_DIGITS;
                            if (in_func == i2a_pkg::FN_OCT_ALT)
                            begin
                                pre_next     = {i2a_pkg::CH_ZERO, 7'd0};
                                pre_len_next = 2'd1;
                            end
                        end
                        default:
                        begin
                            dig_next = {s_tdata, 24'd0};
                            cnt_next = i2a_pkg::HEX_NIBBLES;
                            if ((in_func == i2a_pkg::FN_HEXP_L) ||
                                (in_func == i2a_pkg::FN_HEXP_U))
                            begin
                                pre_next     = {i2a_pkg::CH_ZERO, i2a_pkg::CH_X};
                                pre_len_next = 2'd2;
                            end
                        end
                    endcase
                end
            end
            i2a_pkg::S_DABBLE:
            begin
                dig_next  = {bcd_corr[78:0], bin_reg[i2a_pkg::VALUE_W-1], 8'd0};
                bin_next  = bin_reg << 1;
                step_next = step_reg - 6'd1;
            end
            i2a_pkg::S_SKIP:
            begin
                if (skip_zero)
                begin
                    dig_next = dig_shift;
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            i2a_pkg::S_PREFIX:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    char_next    = pre_reg[2*i2a_pkg::CHAR_W-1 -: i2a_pkg::CHAR_W];
                    last_next    = 1'b0;
                    pre_next     = pre_reg << i2a_pkg::CHAR_W;
                    pre_len_next = pre_len_reg - 2'd1;
                end
            end
            i2a_pkg::S_DIGITS:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    char_next    = i2a_pkg::digit_char(top_digit, is_upper);
                    last_next    = (cnt_reg == 5'd1);
                    dig_next     = dig_shift;
                    cnt_next     = cnt_reg - 5'd1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= i2a_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        bin_reg     <= bin_next;
        dig_reg     <= dig_next;
        cnt_reg     <= cnt_next;
        step_reg    <= step_next;
        pre_reg     <= pre_next;
        pre_len_reg <= pre_len_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

    `ASSERT_IMPLY(a_last_digit_flagged, clk, rst_n,
        (state_reg == i2a_pkg::S_DIGITS) && out_free && (cnt_reg == 5'd1), m_tvalid && m_tlast)
    `ASSERT_IMPLY(a_no_output_in_dabble, clk, rst_n,
        state_reg == i2a_pkg::S_DABBLE, !$rose(m_valid_reg))
    `ASSERT_PROP(a_count_nonzero, clk, rst_n,
        ((state_reg == i2a_pkg::S_SKIP) || (state_reg == i2a_pkg::S_PREFIX) ||
         (state_reg == i2a_pkg::S_DIGITS)) |-> (cnt_reg != 5'd0))
    `ASSERT_IMPLY(a_prefix_not_last, clk, rst_n,
        (state_reg == i2a_pkg::S_PREFIX) && out_free, m_tvalid && !m_tlast)

endmodule
`default_nettype wire
